// File: design/smab_pkg.sv
package smab_pkg;

  localparam int MASK_W    = 17;
  localparam int PIX_W     = 8;
  localparam int INV_W     = 33;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = INV_W;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [MASK_W-1:0] EDGE_LOW_RST  = MASK_W'(32768);
  localparam logic [MASK_W-1:0] EDGE_HIGH_RST = MASK_W'(49152);
  localparam logic [INV_W-1:0]  INV_SPAN_RST  = INV_W'(262144);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_LOW  = 2'd0,
    REG_EDGE_HIGH = 2'd1,
    REG_INV_SPAN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] fg_blue;
    logic [PIX_W-1:0] fg_green;
    logic [PIX_W-1:0] fg_red;
    logic [PIX_W-1:0] bg_blue;
    logic [PIX_W-1:0] bg_green;
    logic [PIX_W-1:0] bg_red;
  } pix_t;

  // below: mask at or under the low edge, above: mask at or over the high edge
  typedef struct packed {
    logic below;
    logic above;
  } edge_flags_t;

endpackage

// File: design/smoothstep_matte_blend_top.sv
// Smoothstep matte compositor: takes one pixel request per clock while in_stall is low
// (mask in Q1.16 plus a foreground and a background BGR pixel) and returns the blended
// pixel, with one result per clock sustained while out_stall is low. The six stages are
// set by the weight chain: edge compare, the span scaling multiply, saturation of t, the
// square, the cubic multiply, and the per-channel blend multiply. Each stage holds only
// while its successor is full and stalled, so bubbles collapse when the output side
// stalls. cfg_ready is always high; write edge_low (index 0), edge_high (index 1) and
// inverse_span (index 2) only while no request is in flight.
module smoothstep_matte_blend_top import smab_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MASK_W-1:0]     mask_value,
  input  logic [PIX_W-1:0]      fg_blue,
  input  logic [PIX_W-1:0]      fg_green,
  input  logic [PIX_W-1:0]      fg_red,
  input  logic [PIX_W-1:0]      bg_blue,
  input  logic [PIX_W-1:0]      bg_green,
  input  logic [PIX_W-1:0]      bg_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_red
);

  localparam int TW      = FRAC_BITS + 1;
  localparam int LW      = FRAC_BITS + 2;
  localparam int SHIFT   = 32 - FRAC_BITS;
  localparam int PROD_W  = MASK_W + INV_W;
  localparam int TRAW_W  = PROD_W - SHIFT;
  localparam int SQ_W    = 2 * TW;
  localparam int CUBE_W  = TW + LW;
  localparam int WRAW_W  = CUBE_W - FRAC_BITS;
  localparam int STAGES  = 6;

  localparam logic [TW-1:0] ONE       = TW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] THREE_ONE = LW'(3) << FRAC_BITS;

  // configuration
  logic [MASK_W-1:0] edge_low;
  logic [MASK_W-1:0] edge_high;
  logic [INV_W-1:0]  inverse_span;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_low     <= EDGE_LOW_RST;
      edge_high    <= EDGE_HIGH_RST;
      inverse_span <= INV_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EDGE_LOW:  edge_low     <= cfg_data[MASK_W-1:0];
        REG_EDGE_HIGH: edge_high    <= cfg_data[MASK_W-1:0];
        REG_INV_SPAN:  inverse_span <= cfg_data[INV_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // pipeline control: a stage advances when it is empty or its successor advances
  logic [STAGES:1]   vld;
  logic [STAGES+1:1] adv;

  assign adv[STAGES+1] = !out_stall;
  for (genvar k = 1; k <= STAGES; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld[STAGES];

  // stage 1: edge compare and offset
  pix_t              pix_in;
  pix_t              pix1, pix2, pix3, pix4, pix5;
  edge_flags_t       flg1, flg2, flg3, flg4;
  logic [MASK_W-1:0] diff;

  assign pix_in = '{fg_blue: fg_blue, fg_green: fg_green, fg_red: fg_red,
                    bg_blue: bg_blue, bg_green: bg_green, bg_red: bg_red};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pix1       <= pix_in;
      flg1.below <= mask_value <= edge_low;
      flg1.above <= mask_value >= edge_high;
      diff       <= mask_value - edge_low;
    end
  end

  // stage 2: scale by the reciprocal span
  logic [PROD_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pix2   <= pix1;
      flg2   <= flg1;
      scaled <= PROD_W'(diff) * PROD_W'(inverse_span);
    end
  end

  // stage 3: drop the scale bits and clamp t to one
  logic [TRAW_W-1:0] t_raw;
  logic [TW-1:0]     t;

  assign t_raw = scaled[PROD_W-1:SHIFT];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pix3 <= pix2;
      flg3 <= flg2;
      t    <= (t_raw > TRAW_W'(ONE)) ? ONE : t_raw[TW-1:0];
    end
  end

  // stage 4: t squared and the linear factor 3 - 2t
  logic [SQ_W-1:0] t_sq_full;
  logic [TW-1:0]   t_sq;
  logic [LW-1:0]   lin;

  assign t_sq_full = SQ_W'(t) * SQ_W'(t);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pix4 <= pix3;
      flg4 <= flg3;
      t_sq <= t_sq_full[FRAC_BITS +: TW];
      lin  <= THREE_ONE - {t, 1'b0};
    end
  end

  // stage 5: weight, with the edge cases forced
  logic [CUBE_W-1:0] cube;
  logic [WRAW_W-1:0] w_raw;
  logic [TW-1:0]     w_next;
  logic [TW-1:0]     w;

  assign cube  = CUBE_W'(t_sq) * CUBE_W'(lin);
  assign w_raw = cube[CUBE_W-1:FRAC_BITS];

  always_comb begin
    priority if (flg4.below) begin
      w_next = '0;
    end else if (flg4.above || (w_raw > WRAW_W'(ONE))) begin
      w_next = ONE;
    end else begin
      w_next = w_raw[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      pix5 <= pix4;
      w    <= w_next;
    end
  end

  // stage 6: per-channel blend
  smab_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk (clk),
    .en  (adv[6]),
    .fg  (pix5.fg_blue),
    .bg  (pix5.bg_blue),
    .w   (w),
    .out (out_blue)
  );

  smab_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk (clk),
    .en  (adv[6]),
    .fg  (pix5.fg_green),
    .bg  (pix5.bg_green),
    .w   (w),
    .out (out_green)
  );

  smab_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk (clk),
    .en  (adv[6]),
    .fg  (pix5.fg_red),
    .bg  (pix5.bg_red),
    .w   (w),
    .out (out_red)
  );

endmodule

// File: design/smab_channel.sv
module smab_channel import smab_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [PIX_W-1:0]     fg,
  input  logic [PIX_W-1:0]     bg,
  input  logic [FRAC_BITS:0]   w,
  output logic [PIX_W-1:0]     out
);

  localparam int TW = FRAC_BITS + 1;
  localparam int SW = PIX_W + TW;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic [TW-1:0] w_inv;
  logic [SW-1:0] fg_part;
  logic [SW-1:0] bg_part;
  logic [SW-1:0] sum;

  assign w_inv   = ONE - w;
  assign fg_part = SW'(fg) * SW'(w);
  assign bg_part = SW'(bg) * SW'(w_inv);
  // sum never exceeds 255 * ONE, so the top bits drop nothing
  assign sum     = fg_part + bg_part;

  always_ff @(posedge clk) begin
    if (en) begin
      out <= sum[FRAC_BITS +: PIX_W];
    end
  end

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smab_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic [63:0] ONE = 64'd1 << FRAC;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 220;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    pix_t pix;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } blended_pix_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MASK_W-1:0] mask_value = '0;
  logic [PIX_W-1:0] fg_blue = '0, fg_green = '0, fg_red = '0;
  logic [PIX_W-1:0] bg_blue = '0, bg_green = '0, bg_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_blue, out_green, out_red;

  // shadow copy of the block's registers
  logic [MASK_W-1:0] edge_low_q = EDGE_LOW_RST;
  logic [MASK_W-1:0] edge_high_q = EDGE_HIGH_RST;
  logic [INV_W-1:0] inv_span_q = INV_SPAN_RST;

  pixel_req_t pending_reqs[$];
  blended_pix_t blend_expect[$];
  pixel_req_t cur_req, next_req;
  blended_pix_t want_pix;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_blended = 0;
  int unsigned n_writes = 0;
  int unsigned n_settings = 0;
  int unsigned errors = 0;

  smoothstep_matte_blend_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mask_value(mask_value),
    .fg_blue(fg_blue), .fg_green(fg_green), .fg_red(fg_red),
    .bg_blue(bg_blue), .bg_green(bg_green), .bg_red(bg_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] matte_weight(logic [MASK_W-1:0] m);
    logic [63:0] t, tsq, w;
    if (m <= edge_low_q) return 64'd0;
    if (m >= edge_high_q) return ONE;
    t = ((64'(m) - 64'(edge_low_q)) * 64'(inv_span_q)) >> (32 - FRAC);
    if (t > ONE) t = ONE;
    tsq = (t * t) >> FRAC;
    w = (tsq * (3 * ONE - 2 * t)) >> FRAC;
    if (w > ONE) w = ONE;
    return w;
  endfunction

  function automatic logic [PIX_W-1:0] mix_channel(logic [PIX_W-1:0] fg, logic [PIX_W-1:0] bg,
                                                   logic [63:0] w);
    logic [63:0] v;
    v = (64'(fg) * w + 64'(bg) * (ONE - w)) >> FRAC;
    return v[PIX_W-1:0];
  endfunction

  function automatic blended_pix_t predict_blend(pixel_req_t r);
    blended_pix_t b;
    logic [63:0] w;
    w = matte_weight(r.mask);
    b.blue = mix_channel(r.pix.fg_blue, r.pix.bg_blue, w);
    b.green = mix_channel(r.pix.fg_green, r.pix.bg_green, w);
    b.red = mix_channel(r.pix.fg_red, r.pix.bg_red, w);
    return b;
  endfunction

  task automatic report_mismatch(string what, int unsigned seq, int got, int want);
    if (errors < 40)
      $display("MISMATCH pixel %0d %s: got %0d expected %0d", seq, what, got, want);
    errors++;
  endtask

  // sender: hold a stalled request, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blend_expect.push_back(predict_blend(cur_req));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          cur_req = next_req;
          in_valid <= 1'b1;
          mask_value <= next_req.mask;
          fg_blue <= next_req.pix.fg_blue;
          fg_green <= next_req.pix.fg_green;
          fg_red <= next_req.pix.fg_red;
          bg_blue <= next_req.pix.bg_blue;
          bg_green <= next_req.pix.bg_green;
          bg_red <= next_req.pix.bg_red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (blend_expect.size() == 0) begin
        report_mismatch("unexpected result", n_blended, 0, 0);
      end else begin
        want_pix = blend_expect.pop_front();
        if (out_blue !== want_pix.blue)
          report_mismatch("out_blue", n_blended, int'(out_blue), int'(want_pix.blue));
        if (out_green !== want_pix.green)
          report_mismatch("out_green", n_blended, int'(out_green), int'(want_pix.green));
        if (out_red !== want_pix.red)
          report_mismatch("out_red", n_blended, int'(out_red), int'(want_pix.red));
      end
      n_blended++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EDGE_LOW: edge_low_q = data[MASK_W-1:0];
      REG_EDGE_HIGH: edge_high_q = data[MASK_W-1:0];
      REG_INV_SPAN: inv_span_q = data;
      default: ;
    endcase
    n_writes++;
  endtask

  // upper data bits on edge writes must be dropped by the block
  task automatic set_edges(int unsigned lo, int unsigned hi, logic [INV_W-1:0] inv);
    write_reg(REG_EDGE_LOW, {16'($urandom), MASK_W'(lo)});
    write_reg(REG_EDGE_HIGH, {16'($urandom), MASK_W'(hi)});
    write_reg(REG_INV_SPAN, inv);
    write_reg(REG_UNUSED, {1'($urandom), 32'($urandom)});
    n_settings++;
  endtask

  task automatic push_req(int unsigned m, int unsigned fb, int unsigned fgr, int unsigned fr,
                          int unsigned bb, int unsigned bgr, int unsigned br);
    pixel_req_t r;
    r.mask = MASK_W'(m);
    r.pix.fg_blue = PIX_W'(fb);
    r.pix.fg_green = PIX_W'(fgr);
    r.pix.fg_red = PIX_W'(fr);
    r.pix.bg_blue = PIX_W'(bb);
    r.pix.bg_green = PIX_W'(bgr);
    r.pix.bg_red = PIX_W'(br);
    pending_reqs.push_back(r);
  endtask

  task automatic drain_all();
    while (pending_reqs.size() != 0 || blend_expect.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  function automatic int unsigned random_mask();
    int lo, hi, v, pick;
    lo = (edge_low_q < edge_high_q) ? int'(edge_low_q) : int'(edge_high_q);
    hi = (edge_low_q < edge_high_q) ? int'(edge_high_q) : int'(edge_low_q);
    pick = $urandom_range(99);
    if (pick < 15) return $urandom_range(131071);
    if (pick < 35) begin
      v = ($urandom_range(1) != 0 ? lo : hi) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 131071) v = 131071;
      return v;
    end
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned random_chan();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(255);
  endfunction

  initial begin
    int unsigned lo, hi, span;
    logic [INV_W-1:0] inv;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: below, at and around both edges, midpoint, above one
    push_req(0, 255, 255, 255, 0, 0, 0);
    push_req(32767, 255, 255, 255, 0, 0, 0);
    push_req(32768, 255, 255, 255, 0, 0, 0);
    push_req(32769, 255, 255, 255, 0, 0, 0);
    push_req(36000, 0, 128, 255, 255, 128, 0);
    push_req(40960, 255, 255, 255, 0, 0, 0);
    push_req(40960, 0, 0, 0, 255, 255, 255);
    push_req(45000, 170, 85, 170, 85, 170, 85);
    push_req(49151, 255, 0, 255, 0, 255, 0);
    push_req(49152, 255, 0, 255, 0, 255, 0);
    push_req(65536, 255, 255, 255, 255, 255, 255);
    push_req(131071, 1, 2, 3, 250, 251, 252);
    drain_all();

    // equal edges: hard step at edge_low
    set_edges(40000, 40000, '0);
    push_req(40000, 255, 255, 255, 0, 0, 0);
    push_req(40001, 255, 255, 255, 0, 0, 0);
    drain_all();

    // reversed edges
    set_edges(50000, 20000, 33'd12345);
    push_req(30000, 200, 100, 50, 10, 20, 30);
    push_req(50000, 200, 100, 50, 10, 20, 30);
    push_req(50001, 200, 100, 50, 10, 20, 30);
    drain_all();

    // inverse span far too large: t saturates at one
    set_edges(0, 65536, {INV_W{1'b1}});
    push_req(1, 255, 255, 255, 0, 0, 0);
    push_req(100, 9, 99, 199, 250, 150, 50);
    drain_all();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_edges(32768, 49152, 33'd262144);
        1: set_edges(0, 65536, 33'd65536);
        2: set_edges(0, 131071, 33'd32768);
        3: begin
          lo = $urandom_range(60000);
          span = $urandom_range(70000, 1);
          set_edges(lo, lo + span, INV_W'((64'd1 << 32) / span));
        end
        4: set_edges(131071, 131071, '0);
        5: begin
          lo = $urandom_range(100000);
          hi = $urandom_range(131071, lo);
          inv = {1'($urandom), 32'($urandom)};
          set_edges(lo, hi, inv);
        end
        6: begin
          lo = $urandom_range(131071, 40000);
          hi = $urandom_range(lo - 1, 0);
          set_edges(lo, hi, {1'($urandom), 32'($urandom)});
        end
        default: begin
          lo = $urandom_range(131070);
          set_edges(lo, lo + 1, INV_W'(64'd1 << 32));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++)
        push_req(random_mask(), random_chan(), random_chan(), random_chan(),
                 random_chan(), random_chan(), random_chan());
      // back up the pipeline while the sender keeps offering
      if (p == 0) hold_asked++;
      drain_all();
    end

    repeat (20) @(posedge clk);
    while (blend_expect.size() != 0) begin
      void'(blend_expect.pop_front());
      report_mismatch("missing result", n_blended, 0, 0);
    end
    $display("Run covered %0d pixels and %0d results over %0d register settings (%0d writes),",
             n_sent, n_blended, n_settings, n_writes);
    $display("including edge extremes, reversed and equal edges, and saturated scaling.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/smab_pkg.sv
design/smab_channel.sv
design/smoothstep_matte_blend_top.sv
tb/sv/tb.sv
